>>> rtl/bfe_pkg.sv
`timescale 1ns / 1ps

package bfe_pkg;

	// Field widths fixed by the item format
	localparam int COLOR_W = 3;
	localparam int POS_W   = 8;
	localparam int OP_W    = 2;
	localparam int COUNT_W = 17;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Default geometry
	localparam int DEF_IMAGE_WIDTH  = 256;
	localparam int DEF_IMAGE_HEIGHT = 256;
	localparam int DEF_STACK_DEPTH  = 4096;

	// Opcodes
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

	// Register file: one register, word addressed on a 3-bit byte address
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_BOUNDARY = 1'b0;
	localparam logic [COLOR_W-1:0] BOUNDARY_RESET = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [COLOR_W-1:0] color;
	} req_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic               status;
		logic [COUNT_W-1:0] filled_count;
	} rsp_t;

	// Stack control and status between sequencer and stack
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stack_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stack_stat_t;

endpackage

>>> rtl/bfe_stack.sv
`timescale 1ns / 1ps

module bfe_stack #(
	parameter int DEPTH   = 4096,
	parameter int ENTRY_W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bfe_pkg::stack_cmd_t cmd,
	input  logic [ENTRY_W-1:0]  wdata,
	output logic [ENTRY_W-1:0]  rdata,
	output bfe_pkg::stack_stat_t stat
);
	import bfe_pkg::*;

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVW = $clog2(DEPTH + 1);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [LVW-1:0]     level_q;
	logic [LVW-1:0]     level_dec;
	logic [ENTRY_W-1:0] rdata_q;

	assign level_dec  = level_q - LVW'(1);
	assign stat.empty = (level_q == '0);
	assign stat.full  = (level_q == LVW'(DEPTH));
	assign rdata      = rdata_q;

	// Fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (cmd.clear) begin
			level_q <= '0;
		end else if (cmd.push) begin
			level_q <= level_q + LVW'(1);
		end else if (cmd.pop) begin
			level_q <= level_dec;
		end
	end

	// Entry memory, registered read of the top entry on pop
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[level_q[AW-1:0]] <= wdata;
		end
		if (cmd.pop) begin
			rdata_q <= mem[level_dec[AW-1:0]];
		end
	end

endmodule

>>> rtl/boundary_fill_engine.sv
`timescale 1ns / 1ps

// Frame store of 3-bit color indices with a 4-connected boundary fill.
// Items enter on req (valid/ready) and each gives one result on rsp.
// Opcodes: write pixel, read pixel, fill from seed; unused codes give zeros.
// boundary_color is set over the APB port at byte address 0 (reset: 4).
// Steps per item: a write, an unused opcode or a seed outside the image
// goes straight to the finish state; a read passes S_RDATA first; a fill
// pushes the seed and then loops over the stack until it is empty.
// Each popped entry costs a stack read, a pixel read and a compare; each
// recolored pixel then visits the four neighbor directions in turn for pushes.
// These steps come from the single read and write port of the pixel
// memory and of the seed stack, which the sequencer visits in turn.
// req_ready is high only while the sequencer is idle; one item is in work
// at a time, so a new item is taken only once the last one is done.
// The result sits in an output register, so the next item is
// taken while rsp waits; a stalled receiver holds the finished result and
// the sequencer waits with the following one until the register frees.
// Reset clears the control state and the stack level; pixel contents are
// undefined until written. A fill that overflows the stack stops at once
// with status 1 and the count of pixels recolored so far.
module boundary_fill_engine #(
	parameter int IMAGE_WIDTH  = bfe_pkg::DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = bfe_pkg::DEF_IMAGE_HEIGHT,
	parameter int STACK_DEPTH  = bfe_pkg::DEF_STACK_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       req_valid,
	output logic                       req_ready,
	input  bfe_pkg::req_t              req,
	// result channel
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output bfe_pkg::rsp_t              rsp,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bfe_pkg::APB_AW-1:0] paddr,
	input  logic [bfe_pkg::APB_DW-1:0] pwdata,
	output logic [bfe_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import bfe_pkg::*;

	localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int PIX_AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int XW     = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
	localparam int YW     = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
	localparam int ENT_W  = XW + YW;

	// Sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_RDATA  = 3'd1;
	localparam logic [2:0] S_POP    = 3'd2;
	localparam logic [2:0] S_FETCH  = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_PUSH   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	// Neighbor push order
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	function automatic logic [PIX_AW-1:0] pix_idx(input logic [XW-1:0] x,
		input logic [YW-1:0] y);
		logic [31:0] sum;
		sum = 32'(y) * 32'(IMAGE_WIDTH) + 32'(x);
		return sum[PIX_AW-1:0];
	endfunction

	logic [2:0]         state_q;
	logic [1:0]         dir_q;
	logic [COLOR_W-1:0] boundary_q;
	logic [COLOR_W-1:0] fill_col_q;
	logic [XW-1:0]      cur_x_q;
	logic [YW-1:0]      cur_y_q;
	logic               rd_inside_q;
	logic [COLOR_W-1:0] res_pix_q;
	logic               res_ovf_q;
	logic [COUNT_W-1:0] count_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [COLOR_W-1:0] pix_mem [PIXELS];
	logic [COLOR_W-1:0] pix_rdata_q;
	logic               pix_we;
	logic [PIX_AW-1:0]  pix_waddr;
	logic [COLOR_W-1:0] pix_wdata;
	logic               pix_re;
	logic [PIX_AW-1:0]  pix_raddr;

	stack_cmd_t         stk_cmd;
	stack_stat_t        stk_stat;
	logic [ENT_W-1:0]   stk_wdata;
	logic [ENT_W-1:0]   stk_rdata;
	logic [XW-1:0]      stk_x;
	logic [YW-1:0]      stk_y;

	logic               req_acc;
	logic               in_inside;
	logic [XW-1:0]      in_x;
	logic [YW-1:0]      in_y;
	logic [PIX_AW-1:0]  in_idx;
	logic               nb_ok;
	logic [XW-1:0]      nb_x;
	logic [YW-1:0]      nb_y;
	logic               fillable;
	logic               out_free;
	logic               cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BOUNDARY);
	assign prdata = (paddr[2] == REG_BOUNDARY) ? APB_DW'(boundary_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boundary_q <= BOUNDARY_RESET;
		end else if (cfg_wr) begin
			boundary_q <= pwdata[COLOR_W-1:0];
		end
	end

	// Input decode
	assign req_ready = (state_q == S_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign in_inside = (32'(req.pos_x) < 32'(IMAGE_WIDTH)) &&
		(32'(req.pos_y) < 32'(IMAGE_HEIGHT));
	assign in_x      = XW'(32'(req.pos_x));
	assign in_y      = YW'(32'(req.pos_y));
	assign in_idx    = pix_idx(in_x, in_y);

	assign stk_x     = stk_rdata[XW-1:0];
	assign stk_y     = stk_rdata[ENT_W-1:XW];
	assign fillable  = (pix_rdata_q != boundary_q) && (pix_rdata_q != fill_col_q);
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Neighbor of the current pixel for this push step
	always_comb begin
		nb_x  = cur_x_q;
		nb_y  = cur_y_q;
		nb_ok = 1'b0;
		unique case (dir_q)
			DIR_UP: begin
				nb_ok = (cur_y_q != '0);
				nb_y  = cur_y_q - YW'(1);
			end
			DIR_DOWN: begin
				nb_ok = (32'(cur_y_q) + 32'd1 < 32'(IMAGE_HEIGHT));
				nb_y  = cur_y_q + YW'(1);
			end
			DIR_LEFT: begin
				nb_ok = (cur_x_q != '0);
				nb_x  = cur_x_q - XW'(1);
			end
			DIR_RIGHT: begin
				nb_ok = (32'(cur_x_q) + 32'd1 < 32'(IMAGE_WIDTH));
				nb_x  = cur_x_q + XW'(1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	// Memory and stack port control
	always_comb begin
		pix_we    = 1'b0;
		pix_waddr = in_idx;
		pix_wdata = req.color;
		pix_re    = 1'b0;
		pix_raddr = in_idx;
		stk_cmd   = '0;
		stk_wdata = {in_y, in_x};
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					pix_we       = (req.opcode == OP_WRITE) && in_inside;
					pix_re       = (req.opcode == OP_READ);
					stk_cmd.push = (req.opcode == OP_FILL) && in_inside;
				end
			end
			S_POP: begin
				stk_cmd.pop = !stk_stat.empty;
			end
			S_FETCH: begin
				pix_re    = 1'b1;
				pix_raddr = pix_idx(stk_x, stk_y);
			end
			S_CHECK: begin
				pix_we    = fillable;
				pix_waddr = pix_idx(cur_x_q, cur_y_q);
				pix_wdata = fill_col_q;
			end
			S_PUSH: begin
				stk_wdata = {nb_y, nb_x};
				if (nb_ok) begin
					stk_cmd.push  = !stk_stat.full;
					stk_cmd.clear = stk_stat.full;
				end
			end
			default: begin
			end
		endcase
	end

	// Pixel memory
	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[pix_waddr] <= pix_wdata;
		end
		if (pix_re) begin
			pix_rdata_q <= pix_mem[pix_raddr];
		end
	end

	bfe_stack #(
		.DEPTH   (STACK_DEPTH),
		.ENTRY_W (ENT_W)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.wdata  (stk_wdata),
		.rdata  (stk_rdata),
		.stat   (stk_stat)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						if (req.opcode == OP_READ) begin
							state_q <= S_RDATA;
						end else if (req.opcode == OP_FILL && in_inside) begin
							state_q <= S_POP;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_RDATA: state_q <= S_FINISH;
				S_POP:   state_q <= stk_stat.empty ? S_FINISH : S_FETCH;
				S_FETCH: state_q <= S_CHECK;
				S_CHECK: state_q <= fillable ? S_PUSH : S_POP;
				S_PUSH: begin
					if (nb_ok && stk_stat.full) begin
						state_q <= S_FINISH;
					end else if (dir_q == DIR_RIGHT) begin
						state_q <= S_POP;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					res_pix_q   <= '0;
					res_ovf_q   <= 1'b0;
					count_q     <= '0;
					fill_col_q  <= req.color;
					rd_inside_q <= in_inside;
				end
			end
			S_RDATA: begin
				res_pix_q <= rd_inside_q ? pix_rdata_q : '0;
			end
			S_FETCH: begin
				cur_x_q <= stk_x;
				cur_y_q <= stk_y;
			end
			S_CHECK: begin
				dir_q <= DIR_UP;
				if (fillable && count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
			S_PUSH: begin
				dir_q <= dir_q + 2'd1;
				if (nb_ok && stk_stat.full) begin
					res_ovf_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			rsp_q.pixel_color  <= res_pix_q;
			rsp_q.status       <= res_ovf_q;
			rsp_q.filled_count <= count_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
